/* hdl/eep24_pkg.sv */
// Shared constants and types for the 24C04-style I2C EEPROM slave.
package eep24_pkg;

	localparam int MEM_BYTES  = 512;
	localparam int PAGE_BYTES = 16;
	localparam int PTR_W      = $clog2(MEM_BYTES);
	localparam int PAGE_W     = $clog2(PAGE_BYTES);

	localparam logic [7:0] DEV_ADDR_RESET = 8'hA0;
	localparam logic [7:0] DEV_ADDR_MASK  = 8'hFC;

	// func codes; code three is unused: it changes no state but still gets a reply
	localparam logic [1:0] FUNC_ADDR  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_RDWAIT = 3'b100
	} state_t;

	// one write port and one read port per cycle
	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [PTR_W-1:0] raddr;
	} mem_req_t;

endpackage

/* hdl/eep24_ram.sv */
// Byte store: synchronous RAM, one write and one registered read per cycle.
module eep24_ram (
	input  logic                 clk,
	input  eep24_pkg::mem_req_t  req,
	output logic [7:0]           rdata
);

	logic [7:0] mem [eep24_pkg::MEM_BYTES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

/* hdl/i2c_eeprom_24c04_slave.sv */
// Top level: byte-event 24C04-style I2C EEPROM slave with a 512-byte store.
//
// Each request on the slave stream is one bus byte event (address byte, write
// byte or read) and gives exactly one result on the master stream. After
// reset the store is swept to zero, one byte a cycle, and s_tready stays low
// until the sweep ends; device_address writes are taken during the sweep.
// Address and write results go straight to the output register; a read waits
// in ST_RDWAIT for the registered store RAM read, with s_tready low. A result
// waits in the output register while the next request is taken, so long as
// the master side drains it. The user writes the device address through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module i2c_eeprom_24c04_slave (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,    // device_address

	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,      // [7:0] byte_value
	input  logic [1:0] s_tuser,      // [1:0] func

	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,      // [7:0] read_data
	output logic [0:0] m_tuser       // [0] nack
);

	localparam int PTR_W  = eep24_pkg::PTR_W;
	localparam int PAGE_W = eep24_pkg::PAGE_W;

	eep24_pkg::state_t   state_q;
	eep24_pkg::mem_req_t mem_req;

	logic [PTR_W-1:0] clr_q;       // clearing sweep address
	logic [PTR_W-1:0] ptr_q;       // data pointer
	logic             pending_q;   // word-address byte expected
	logic [7:0]       dev_q;       // configured device address

	logic             out_valid_q;
	logic [7:0]       out_data_q;
	logic             out_nack_q;

	logic [7:0]       rdata;
	logic             accept;
	logic             is_addr;
	logic             is_write;
	logic             is_read;
	logic             addr_match;

	assign s_tready = (state_q == eep24_pkg::ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign is_addr    = (s_tuser == eep24_pkg::FUNC_ADDR);
	assign is_write   = (s_tuser == eep24_pkg::FUNC_WRITE);
	assign is_read    = (s_tuser == eep24_pkg::FUNC_READ);
	assign addr_match = ((s_tdata & eep24_pkg::DEV_ADDR_MASK) == dev_q);

	// RAM requests: zero sweep after reset, else data writes and reads
	always_comb begin
		mem_req       = '0;
		mem_req.raddr = ptr_q;
		if (state_q == eep24_pkg::ST_CLEAR) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = clr_q;
			mem_req.wdata = 8'h00;
		end else begin
			mem_req.we    = accept && is_write && !pending_q;
			mem_req.waddr = ptr_q;
			mem_req.wdata = s_tdata;
			mem_req.re    = accept && is_read;
		end
	end

	eep24_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// sequencer: sweep, idle, read wait
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eep24_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				eep24_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PTR_W'(eep24_pkg::MEM_BYTES - 1)) begin
						state_q <= eep24_pkg::ST_IDLE;
					end
				end
				eep24_pkg::ST_IDLE: begin
					if (accept && is_read) begin
						state_q <= eep24_pkg::ST_RDWAIT;
					end
				end
				eep24_pkg::ST_RDWAIT: begin
					state_q <= eep24_pkg::ST_IDLE;
				end
				default: begin
					state_q <= eep24_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// device address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= eep24_pkg::DEV_ADDR_RESET;
		end else if (cfg_we) begin
			dev_q <= cfg_wdata;
		end
	end

	// pointer and word-address flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			pending_q <= 1'b0;
		end else if (accept) begin
			case (s_tuser)
				eep24_pkg::FUNC_ADDR: begin
					// write direction: bit 1 of the address byte picks the block
					if (addr_match && !s_tdata[0]) begin
						pending_q <= 1'b1;
						ptr_q     <= {{(PTR_W-1){1'b0}}, s_tdata[1]};
					end
				end
				eep24_pkg::FUNC_WRITE: begin
					if (pending_q) begin
						pending_q <= 1'b0;
						ptr_q     <= {ptr_q[0], s_tdata};
					end else begin
						// wrap inside the page
						ptr_q <= {ptr_q[PTR_W-1:PAGE_W], ptr_q[PAGE_W-1:0] + 1'b1};
					end
				end
				eep24_pkg::FUNC_READ: begin
					ptr_q <= ptr_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// output register; read data is taken from the store RAM's registered read in ST_RDWAIT
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !is_read) || state_q == eep24_pkg::ST_RDWAIT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == eep24_pkg::ST_RDWAIT) begin
			out_data_q <= rdata;
			out_nack_q <= 1'b0;
		end else if (accept && !is_read) begin
			out_data_q <= 8'h00;
			out_nack_q <= is_addr && !addr_match;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_nack_q;

endmodule

/* verif/tb_i2c_eeprom_24c04_slave.sv */
// Testbench for the 24C04-style I2C EEPROM slave: shadow-memory prediction of nack/read data.
`timescale 1ns / 100ps

module tb_i2c_eeprom_24c04_slave;

	// func code three has no name in the package; the block changes no state on it but still replies
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 200000;  // sweep + ~1200 requests with stalls, many times over
	localparam int DRAIN_CYCLES = 8;       // margin after the last reply, for a read's RAM and output registers

	typedef struct packed {
		logic       nack;
		logic [7:0] read_data;
	} reply_t;

	// Shadow of the EEPROM: byte store, data pointer, word-address flag and
	// device address; predicts one reply per request and checks replies in order.
	class eeprom_shadow;
		logic [7:0]                  mem [eep24_pkg::MEM_BYTES];
		logic [eep24_pkg::PTR_W-1:0] ptr;
		logic                        word_pending;
		logic [7:0]                  dev_addr;
		reply_t                      expected_replies [$];
		int                          errors;

		function new();
			foreach (mem[i]) mem[i] = 8'h00;
			ptr          = '0;
			word_pending = 1'b0;
			dev_addr     = eep24_pkg::DEV_ADDR_RESET;
			errors       = 0;
		endfunction

		function void note_request(logic [1:0] func, logic [7:0] b);
			reply_t r;
			r = '0;
			case (func)
				eep24_pkg::FUNC_ADDR: begin
					if ((b & eep24_pkg::DEV_ADDR_MASK) != dev_addr) begin
						r.nack = 1'b1;
					end else if (!b[0]) begin
						// write direction: block select sits in bit 0 until the
						// word address shifts it up to bit 8
						word_pending = 1'b1;
						ptr          = {8'h00, b[1]};
					end
				end
				eep24_pkg::FUNC_WRITE: begin
					if (word_pending) begin
						word_pending = 1'b0;
						ptr          = {ptr[0], b};
					end else begin
						mem[ptr] = b;
						// advance inside the 16-byte page only
						ptr = {ptr[eep24_pkg::PTR_W-1:eep24_pkg::PAGE_W],
							ptr[eep24_pkg::PAGE_W-1:0] + 1'b1};
					end
				end
				eep24_pkg::FUNC_READ: begin
					// pending flag is left alone on reads
					r.read_data = mem[ptr];
					ptr         = ptr + 1'b1;
				end
				default: ;
			endcase
			expected_replies.push_back(r);
		endfunction

		function void check_result(logic nack, logic [7:0] read_data);
			reply_t e;
			if (expected_replies.size() == 0) begin
				$display("%0t: reply with nothing pending: nack %0d read_data %02h",
					$time, nack, read_data);
				errors++;
				return;
			end
			e = expected_replies.pop_front();
			if (nack !== e.nack) begin
				$display("%0t: nack expected %0d, got %0d", $time, e.nack, nack);
				errors++;
			end
			if (read_data !== e.read_data) begin
				$display("%0t: read_data expected %02h, got %02h",
					$time, e.read_data, read_data);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;     // [7:0] byte_value
	logic [1:0] s_tuser;     // [1:0] func
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;     // [7:0] read_data
	logic [0:0] m_tuser;     // [0] nack

	eeprom_shadow model = new();
	int send_idle  = 20;     // percent of cycles the request side holds off
	int recv_idle  = 54;     // percent of cycles the reply side stalls
	int sent_items = 0;
	int cycles     = 0;

	i2c_eeprom_24c04_slave dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor both streams at the edge (pre-edge values); check the reply
	// before noting a new request so an unexpected reply never pairs with it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				model.check_result(m_tuser[0], m_tdata);
			if (s_tvalid && s_tready)
				model.note_request(s_tuser, s_tdata);
		end
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL i2c_eeprom_24c04_slave");
			$finish;
		end
	end

	// Present one request and hold it until taken. Called at a clock edge;
	// tvalid stays high into the next request when no gap is drawn.
	task automatic send_request(input logic [1:0] func, input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		if (func != FUNC_UNUSED)
			sent_items++;
	endtask

	// block idle only: nothing in flight
	task automatic write_dev_addr(input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we       <= 1'b0;
		model.dev_addr = v;
	endtask

	// one edge first so the monitor has noted the last accepted request
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (model.expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] addr_byte(input logic blk, input logic rd);
		return {model.dev_addr[7:2], blk, rd};
	endfunction

	// Mostly well-formed bus transactions with random content; the rest is
	// broken sequences and raw noise.
	task automatic run_random(input int n);
		int target;
		int kind;
		int cnt;
		target = sent_items + n;
		while (sent_items < target) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				// page write: address, word address, data (may wrap the page)
				send_request(eep24_pkg::FUNC_ADDR, addr_byte(1'($urandom), 1'b0));
				send_request(eep24_pkg::FUNC_WRITE, 8'($urandom));
				cnt = $urandom_range(1, 20);
				repeat (cnt) send_request(eep24_pkg::FUNC_WRITE, 8'($urandom));
			end else if (kind < 65) begin
				// random read: set pointer, switch to read direction, read on
				send_request(eep24_pkg::FUNC_ADDR, addr_byte(1'($urandom), 1'b0));
				send_request(eep24_pkg::FUNC_WRITE, 8'($urandom));
				send_request(eep24_pkg::FUNC_ADDR, addr_byte(1'($urandom), 1'b1));
				cnt = $urandom_range(1, 24);
				repeat (cnt) send_request(eep24_pkg::FUNC_READ, 8'($urandom));
			end else if (kind < 78) begin
				// current-address read
				send_request(eep24_pkg::FUNC_ADDR, addr_byte(1'($urandom), 1'b1));
				cnt = $urandom_range(1, 24);
				repeat (cnt) send_request(eep24_pkg::FUNC_READ, 8'($urandom));
			end else if (kind < 90) begin
				if ($urandom_range(1)) begin
					// wrong device address
					send_request(eep24_pkg::FUNC_ADDR,
						{model.dev_addr[7:2] ^ 6'($urandom_range(1, 63)),
						2'($urandom)});
				end else begin
					// read slipped in while the word address is pending
					send_request(eep24_pkg::FUNC_ADDR, addr_byte(1'($urandom), 1'b0));
					send_request(eep24_pkg::FUNC_READ, 8'($urandom));
					send_request(eep24_pkg::FUNC_WRITE, 8'($urandom));
				end
			end else begin
				send_request(2'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		logic [7:0] dev_list [6];
		int         phase;
		dev_list = '{8'h00, 8'hFC, 8'h5C, 8'hFF, 8'h24, 8'hA0};

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 8'h00;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'h00;
		s_tuser   <= eep24_pkg::FUNC_ADDR;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// taken during the clearing sweep
		write_dev_addr(8'hA0);

		// directed: cleared store, unused code, mismatches, page wrap,
		// store wrap, read-direction match, reads while word address pending
		send_request(eep24_pkg::FUNC_READ,   8'h00);
		send_request(FUNC_UNUSED,            8'hFF);
		send_request(eep24_pkg::FUNC_ADDR,   8'h00);
		send_request(eep24_pkg::FUNC_ADDR,   8'hFF);
		send_request(eep24_pkg::FUNC_ADDR,   8'hA0);
		send_request(eep24_pkg::FUNC_WRITE,  8'h0E);
		send_request(eep24_pkg::FUNC_WRITE,  8'h11);
		send_request(eep24_pkg::FUNC_WRITE,  8'h22);
		send_request(eep24_pkg::FUNC_WRITE,  8'h33);   // wraps to page start
		send_request(eep24_pkg::FUNC_ADDR,   8'hA2);
		send_request(eep24_pkg::FUNC_READ,   8'h00);   // pending stays set
		send_request(eep24_pkg::FUNC_WRITE,  8'hFF);   // pointer to 0x0FF, the read moved bit 0
		send_request(eep24_pkg::FUNC_WRITE,  8'hAB);
		send_request(eep24_pkg::FUNC_ADDR,   8'hA2);
		send_request(eep24_pkg::FUNC_WRITE,  8'hFF);
		send_request(eep24_pkg::FUNC_ADDR,   8'hA3);   // read direction, no change
		send_request(eep24_pkg::FUNC_READ,   8'h00);
		send_request(eep24_pkg::FUNC_READ,   8'h00);   // wrapped to the store start
		send_request(eep24_pkg::FUNC_READ,   8'h55);
		send_request(eep24_pkg::FUNC_ADDR,   8'hA1);
		send_request(eep24_pkg::FUNC_READ,   8'hFF);
		send_request(eep24_pkg::FUNC_ADDR,   8'hA0);
		send_request(eep24_pkg::FUNC_READ,   8'h00);
		send_request(eep24_pkg::FUNC_WRITE,  8'h0F);
		send_request(eep24_pkg::FUNC_WRITE,  8'hFF);
		drain();

		// three idle modes, two device addresses each
		for (phase = 0; phase < 6; phase++) begin
			case (phase / 2)
				0: begin send_idle = 20; recv_idle = 54; end
				1: begin send_idle = 54; recv_idle = 20; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			write_dev_addr(dev_list[phase]);
			run_random(190);
			drain();
		end

		if (model.errors == 0 && model.expected_replies.size() == 0)
			$display("PASS i2c_eeprom_24c04_slave");
		else
			$display("FAIL i2c_eeprom_24c04_slave");
		$finish;
	end

endmodule

/* filelist.f */
hdl/eep24_pkg.sv
hdl/eep24_ram.sv
hdl/i2c_eeprom_24c04_slave.sv
verif/tb_i2c_eeprom_24c04_slave.sv
